// File: src/mcpa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encodings of the point assignment block.
package mcpa_pkg;

  localparam int MAX_POINTS_DEF  = 32;
  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 10;

  localparam int CFG_W      = 6;
  localparam int IDX_OUT_W  = 5;
  localparam int DIST_OUT_W = 27;
  localparam int TOTAL_W    = 32;
  localparam int RES_BITS   = 2 * IDX_OUT_W + DIST_OUT_W + TOTAL_W;
  localparam int OUT_W      = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SQR,
    D_SUM,
    D_ROOT
  } dist_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRD,
    S_DGO,
    S_DWT,
    S_ROW,
    S_RESTART,
    S_SCAN,
    S_TEST,
    S_POP,
    S_UNPOP,
    S_DMIN,
    S_ADJ,
    S_NEXT,
    S_OUTRD,
    S_OUTWR
  } solve_state_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]    total_cost;
    logic [DIST_OUT_W-1:0] pair_distance;
    logic [IDX_OUT_W-1:0]  matched_first_index;
    logic [IDX_OUT_W-1:0]  second_index;
  } mcpa_result_t;

endpackage

// File: src/mcpa_dist.sv
`timescale 1ns / 1ps
// Distance unit: squares the coordinate differences and takes a rounded square root.
module mcpa_dist import mcpa_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int RB         = ((2 * (COORD_BITS + 1) + 1 + 2 * FRAC_BITS) + 1) / 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output logic                         done,
  output logic [RB-1:0]                distance
);

  localparam int D     = COORD_BITS + 1;
  localparam int CNT_W = $clog2(RB + 1);

  dist_state_t state, state_next;

  logic signed [D-1:0] diff_x, diff_y;
  logic [D-1:0]        dx, dy;
  logic [2*D-1:0]      sqx, sqy;
  logic [2*RB-1:0]     rad;
  logic [RB+1:0]       rem, rem_sh, trial;
  logic [RB-1:0]       root;
  logic [CNT_W-1:0]    cnt;
  logic                last_step;

  assign diff_x = D'(ax) - D'(bx);
  assign diff_y = D'(ay) - D'(by);
  assign rem_sh = {rem[RB-1:0], rad[2*RB-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign last_step = (cnt == CNT_W'(RB - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (start) state_next = D_SQR;
      D_SQR:  state_next = D_SUM;
      D_SUM:  state_next = D_ROOT;
      D_ROOT: if (last_step) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        dx <= diff_x[D-1] ? D'(-diff_x) : D'(diff_x);
        dy <= diff_y[D-1] ? D'(-diff_y) : D'(diff_y);
      end
      D_SQR: begin
        sqx <= dx * dx;
        sqy <= dy * dy;
      end
      D_SUM: begin
        rad  <= (2*RB)'({1'b0, sqx} + {1'b0, sqy}) << (2 * FRAC_BITS);
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      D_ROOT: begin
        rad <= rad << 2;
        cnt <= cnt + CNT_W'(1);
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RB-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RB-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // The root and done are both registered at the last digit step; round up when the
  // remainder exceeds the root.
  logic fin;
  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= (state == D_ROOT) && last_step;
    end
  end

  assign done = fin;
  assign distance = root + RB'(rem > {2'b00, root});

endmodule

// File: src/mcpa_solver.sv
`timescale 1ns / 1ps
// Solver: point and cost memories, labels, augmenting search and result output.
module mcpa_solver import mcpa_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CNT_W-1:0]        n,
  input  logic                    pt_we,
  input  logic                    pt_set,
  input  logic [IDX_W-1:0]        pt_idx,
  input  logic [2*COORD_BITS-1:0] pt_data,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_ready,
  output mcpa_result_t            res,
  output logic                    res_last
);

  localparam int RB    = ((2 * (COORD_BITS + 1) + 1 + 2 * FRAC_BITS) + 1) / 2;
  localparam int LBL_W = RB + 4;

  solve_state_t state, state_next;

  logic [2*COORD_BITS-1:0] first_mem  [MAX_POINTS];
  logic [2*COORD_BITS-1:0] second_mem [MAX_POINTS];
  logic [RB-1:0]           cost_mem   [2**(2*IDX_W)];
  logic [2*IDX_W-1:0]      stack_mem  [MAX_POINTS];
  logic [2*COORD_BITS-1:0] pa_rd, pb_rd;
  logic [RB-1:0]           cost_rd;
  logic [2*IDX_W-1:0]      stack_rd;

  logic signed [LBL_W-1:0] row_label    [MAX_POINTS];
  logic signed [LBL_W-1:0] column_label [MAX_POINTS];
  logic signed [LBL_W-1:0] column_slack [MAX_POINTS];
  logic [IDX_W:0]          column_owner [MAX_POINTS];
  logic [MAX_POINTS-1:0]   row_visited, column_visited, slack_none;

  logic [CNT_W-1:0] n_r, cur_j, sp;
  logic [IDX_W-1:0] di, dj, row, cur_i, k;
  logic [RB-1:0]    dmin;
  logic signed [LBL_W-1:0] delta;
  logic             dfound;
  logic [TOTAL_W-1:0] total;

  logic             dist_start, dist_done;
  logic [RB-1:0]    distance;

  mcpa_dist #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .RB         (RB)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .ax       (pa_rd[COORD_BITS-1:0]),
    .ay       (pa_rd[2*COORD_BITS-1:COORD_BITS]),
    .bx       (pb_rd[COORD_BITS-1:0]),
    .by       (pb_rd[2*COORD_BITS-1:COORD_BITS]),
    .done     (dist_done),
    .distance (distance)
  );

  logic [IDX_W-1:0] cj;
  logic [CNT_W-1:0] n_m1;
  logic             di_last, dj_last, row_last, k_last, sp_zero;
  logic signed [LBL_W-1:0] gap;
  logic [RB-1:0]    newmin;
  logic             cand, found_new;
  logic [IDX_W-1:0] owner_k;
  logic [IDX_W-1:0] stk_i, stk_j;

  assign cj       = cur_j[IDX_W-1:0];
  assign n_m1     = n_r - CNT_W'(1);
  assign di_last  = ({1'b0, di} == (IDX_W+1)'(n_m1));
  assign dj_last  = ({1'b0, dj} == (IDX_W+1)'(n_m1));
  assign row_last = ({1'b0, row} == (IDX_W+1)'(n_m1));
  assign k_last   = ({1'b0, k} == (IDX_W+1)'(n_m1));
  assign sp_zero  = (sp == '0);
  assign gap      = $signed({{(LBL_W-RB){1'b0}}, cost_rd}) - row_label[cur_i]
                    - column_label[cj];
  assign newmin   = (dj == '0 || distance < dmin) ? distance : dmin;
  assign cand     = !column_visited[k] && !slack_none[k]
                    && (!dfound || column_slack[k] < delta);
  assign found_new = dfound || cand;
  assign owner_k  = (column_owner[k] == '0) ? '0 : IDX_W'(column_owner[k] - 1'b1);
  assign stk_i    = stack_rd[2*IDX_W-1:IDX_W];
  assign stk_j    = stack_rd[IDX_W-1:0];
  assign dist_start = (state == S_DGO);
  assign idle     = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_DRD;
      S_DRD:     state_next = S_DGO;
      S_DGO:     state_next = S_DWT;
      S_DWT:     if (dist_done) state_next = (di_last && dj_last) ? S_ROW : S_DRD;
      S_ROW:     state_next = S_SCAN;
      S_RESTART: state_next = S_SCAN;
      S_SCAN: begin
        if (cur_j == n_r) state_next = sp_zero ? S_DMIN : S_POP;
        else if (!column_visited[cj]) state_next = S_TEST;
      end
      S_TEST: begin
        if (gap == '0 && column_owner[cj] == '0) state_next = sp_zero ? S_NEXT : S_UNPOP;
        else state_next = S_SCAN;
      end
      S_POP:     state_next = S_SCAN;
      S_UNPOP:   if (sp_zero) state_next = S_NEXT;
      S_DMIN:    if (k_last) state_next = found_new ? S_ADJ : S_NEXT;
      S_ADJ:     if (k_last) state_next = S_RESTART;
      S_NEXT:    state_next = row_last ? S_OUTRD : S_ROW;
      S_OUTRD:   if (!res_valid) state_next = S_OUTWR;
      S_OUTWR:   state_next = k_last ? S_IDLE : S_OUTRD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we && !pt_set) first_mem[pt_idx] <= pt_data;
    if (pt_we && pt_set) second_mem[pt_idx] <= pt_data;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          n_r <= n;
          di  <= '0;
          dj  <= '0;
          row <= '0;
          sp  <= '0;
          for (int c = 0; c < MAX_POINTS; c++) begin
            column_label[c] <= '0;
            column_owner[c] <= '0;
          end
        end
      end
      S_DRD: begin
        pa_rd <= first_mem[di];
        pb_rd <= second_mem[dj];
      end
      S_DWT: begin
        if (dist_done) begin
          cost_mem[{di, dj}] <= distance;
          dmin <= newmin;
          if (dj_last) begin
            row_label[di] <= $signed({{(LBL_W-RB){1'b0}}, newmin});
            dj <= '0;
            di <= di + 1'b1;
          end else begin
            dj <= dj + 1'b1;
          end
        end
      end
      S_ROW, S_RESTART: begin
        if (state == S_ROW) slack_none <= '1;
        row_visited    <= {{(MAX_POINTS-1){1'b0}}, 1'b1} << row;
        column_visited <= '0;
        cur_i <= row;
        cur_j <= '0;
        sp    <= '0;
      end
      S_SCAN: begin
        if (cur_j == n_r) begin
          if (!sp_zero) begin
            stack_rd <= stack_mem[IDX_W'(sp - 1'b1)];
            sp <= sp - 1'b1;
          end else begin
            k      <= '0;
            dfound <= 1'b0;
          end
        end else if (column_visited[cj]) begin
          cur_j <= cur_j + 1'b1;
        end else begin
          cost_rd <= cost_mem[{cur_i, cj}];
        end
      end
      S_TEST: begin
        if (gap == '0) begin
          column_visited[cj] <= 1'b1;
          if (column_owner[cj] == '0) begin
            column_owner[cj] <= (IDX_W+1)'(cur_i) + 1'b1;
            if (!sp_zero) begin
              stack_rd <= stack_mem[IDX_W'(sp - 1'b1)];
              sp <= sp - 1'b1;
            end
          end else begin
            // Column already taken: descend into the row that owns it.
            stack_mem[IDX_W'(sp)] <= {cur_i, cj};
            sp <= sp + 1'b1;
            cur_i <= IDX_W'(column_owner[cj] - 1'b1);
            row_visited[IDX_W'(column_owner[cj] - 1'b1)] <= 1'b1;
            cur_j <= '0;
          end
        end else begin
          if (slack_none[cj] || gap < column_slack[cj]) begin
            column_slack[cj] <= gap;
            slack_none[cj]   <= 1'b0;
          end
          cur_j <= cur_j + 1'b1;
        end
      end
      S_POP: begin
        cur_i <= stk_i;
        cur_j <= CNT_W'(stk_j) + 1'b1;
      end
      S_UNPOP: begin
        column_owner[stk_j] <= (IDX_W+1)'(stk_i) + 1'b1;
        if (!sp_zero) begin
          stack_rd <= stack_mem[IDX_W'(sp - 1'b1)];
          sp <= sp - 1'b1;
        end
      end
      S_DMIN: begin
        if (cand) begin
          delta  <= column_slack[k];
          dfound <= 1'b1;
        end
        k <= k_last ? '0 : k + 1'b1;
      end
      S_ADJ: begin
        if (row_visited[k]) row_label[k] <= row_label[k] + delta;
        if (column_visited[k]) column_label[k] <= column_label[k] - delta;
        else if (!slack_none[k]) column_slack[k] <= column_slack[k] - delta;
        k <= k_last ? '0 : k + 1'b1;
      end
      S_NEXT: begin
        row   <= row + 1'b1;
        k     <= '0;
        total <= '0;
      end
      S_OUTRD: begin
        if (!res_valid) cost_rd <= cost_mem[{owner_k, k}];
      end
      S_OUTWR: begin
        total <= total + TOTAL_W'(cost_rd);
        res.second_index        <= IDX_OUT_W'(k);
        res.matched_first_index <= IDX_OUT_W'(owner_k);
        res.pair_distance       <= DIST_OUT_W'(cost_rd);
        res.total_cost          <= total + TOTAL_W'(cost_rd);
        res_last                <= k_last;
        k <= k + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUTWR) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cur_j <= n_r && sp < n_r)
    else $error("search column or stack depth beyond point count");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> row_visited[cur_i])
    else $error("active search row is not marked visited");

  a_test_fresh: assert property (@(posedge clk) disable iff (rst)
    state == S_TEST |-> !column_visited[cj])
    else $error("tested a column already on the path");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    state == S_OUTWR |-> !res_valid)
    else $error("result overwritten before it was taken");

endmodule

// File: src/min_cost_point_assignment_top.sv
`timescale 1ns / 1ps
// Top level of the minimum-cost point assignment block: loading, configuration and streams.
//
// The block takes point_count points of the first set and then point_count
// points of the second set as input requests, builds every pair distance
// (fixed point, FRAC_BITS fraction bits, rounded to nearest) into a cost
// memory and solves the minimum-cost perfect matching with the Hungarian
// method. Requests of the wrong set are dropped. The request that completes
// the second set starts the solve; the block then accepts no input until the
// last result has been handed to the output register. The solve is
// sequential: each of the N*N distances passes through the shared
// square-root unit (RB = 28 at the default widths, one root bit per cycle),
// then the augmenting searches test one column at a time through the single
// cost memory port. A row may need up to N search passes, since every label
// update restarts the search, so the worst-case solve time grows as N to the
// fourth; typical inputs need a small fraction of that. Results leave one at
// a time, each once the previous one has been taken, in ascending second-set
// order; the last carries tlast and the final total.
// Writing the point count discards a partial load; a count of zero acts as
// one and a count above MAX_POINTS acts as MAX_POINTS.
module min_cost_point_assignment_top import mcpa_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // coord_x, coord_y
  input  logic             s_axis_tuser,   // point_set
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // second_index, matched_first_index,
                                           // pair_distance, total_cost
  output logic             m_axis_tlast    // last_pair
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LD_W  = $clog2(2 * MAX_POINTS + 1);

  logic [CFG_W-1:0] point_count;
  logic [LD_W-1:0]  loaded_count;
  logic [CNT_W-1:0] n_eff;
  logic [LD_W-1:0]  n_ld;
  logic             accept, loading_first, pt_we, start, idle;
  mcpa_result_t     res;

  always_comb begin
    if (point_count == '0) n_eff = CNT_W'(1);
    else if (int'(point_count) > MAX_POINTS) n_eff = CNT_W'(MAX_POINTS);
    else n_eff = CNT_W'(point_count);
  end

  assign n_ld          = LD_W'(n_eff);
  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign loading_first = (loaded_count < n_ld);
  // A request is kept only when its set matches the set being loaded.
  assign pt_we = accept && (s_axis_tuser == !loading_first);
  assign start = pt_we && !loading_first && (loaded_count + 1'b1 == (n_ld << 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= CFG_W'(1);
      loaded_count <= '0;
    end else if (cfg_we) begin
      point_count  <= cfg_data;
      loaded_count <= '0;
    end else if (pt_we) begin
      loaded_count <= start ? '0 : loaded_count + 1'b1;
    end
  end

  mcpa_solver #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n         (n_eff),
    .pt_we     (pt_we),
    .pt_set    (!loading_first),
    .pt_idx    (loading_first ? IDX_W'(loaded_count) : IDX_W'(loaded_count - n_ld)),
    .pt_data   (s_axis_tdata[2*COORD_BITS-1:0]),
    .idle      (idle),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res),
    .res_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(res);

endmodule

// File: test/min_cost_point_assignment_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the minimum-cost point assignment block.
module min_cost_point_assignment_top_tb;
  import mcpa_pkg::*;

  localparam int NMAX = MAX_POINTS_DEF;
  localparam longint SLACK_NONE = 64'sh7fffffffffffffff;

  typedef struct {
    mcpa_result_t fields;
    bit           last_pair;
  } pair_result_t;

  typedef struct {
    bit      point_set;
    shortint x;
    shortint y;
    bit      has_exp;
    int      exp_dist;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  min_cost_point_assignment_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block state used by the predictor.
  int      count_reg;
  int      points_loaded;
  longint  first_x [NMAX], first_y [NMAX], second_x [NMAX], second_y [NMAX];
  longint  pair_cost [NMAX][NMAX];
  longint  row_lab [NMAX], col_lab [NMAX], col_slack [NMAX];
  bit      row_seen [NMAX], col_seen [NMAX];
  int      col_owner [NMAX];

  pair_result_t expected_pairs [$];
  int  fail_count = 0;
  int  results_seen = 0;
  int  problems_solved = 0;
  int  requests_sent = 0;
  bit  quiet = 1'b0;
  int  out_stall = 0;

  function automatic longint pair_distance_of(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx, dy, v, res, bitv;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    v = (dx * dx + dy * dy) << (2 * FRAC_BITS_DEF);
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    // v now holds the remainder of the integer root; round up past the half.
    if (v > res) res++;
    return res;
  endfunction

  // Augmenting search from row i over tight edges.
  function automatic bit augment_from(int i, int n);
    longint gap;
    row_seen[i] = 1'b1;
    for (int j = 0; j < n; j++) begin
      if (col_seen[j]) continue;
      gap = pair_cost[i][j] - row_lab[i] - col_lab[j];
      if (gap == 0) begin
        col_seen[j] = 1'b1;
        if (col_owner[j] == 0 || augment_from(col_owner[j] - 1, n)) begin
          col_owner[j] = i + 1;
          return 1'b1;
        end
      end else if (gap < col_slack[j]) begin
        col_slack[j] = gap;
      end
    end
    return 1'b0;
  endfunction

  task automatic solve_assignment(int n);
    longint lo, delta, total;
    int owner;
    pair_result_t res;
    for (int i = 0; i < n; i++) begin
      lo = SLACK_NONE;
      for (int j = 0; j < n; j++) begin
        pair_cost[i][j] = pair_distance_of(first_x[i], first_y[i], second_x[j], second_y[j]);
        if (pair_cost[i][j] < lo) lo = pair_cost[i][j];
      end
      row_lab[i] = lo;
    end
    for (int j = 0; j < n; j++) begin
      col_lab[j] = 0;
      col_owner[j] = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) col_slack[j] = SLACK_NONE;
      forever begin
        for (int k = 0; k < NMAX; k++) begin
          row_seen[k] = 1'b0;
          col_seen[k] = 1'b0;
        end
        if (augment_from(i, n)) break;
        delta = SLACK_NONE;
        for (int j = 0; j < n; j++)
          if (!col_seen[j] && col_slack[j] < delta) delta = col_slack[j];
        if (delta == SLACK_NONE) break;
        for (int r = 0; r < n; r++)
          if (row_seen[r]) row_lab[r] += delta;
        for (int j = 0; j < n; j++) begin
          if (col_seen[j]) col_lab[j] -= delta;
          else if (col_slack[j] != SLACK_NONE) col_slack[j] -= delta;
        end
      end
    end
    total = 0;
    for (int j = 0; j < n; j++) begin
      owner = col_owner[j] ? col_owner[j] - 1 : 0;
      total += pair_cost[owner][j];
      res.fields.second_index = IDX_OUT_W'(j);
      res.fields.matched_first_index = IDX_OUT_W'(owner);
      res.fields.pair_distance = DIST_OUT_W'(pair_cost[owner][j]);
      res.fields.total_cost = TOTAL_W'(total);
      res.last_pair = (j == n - 1);
      expected_pairs.push_back(res);
    end
    problems_solved++;
  endtask

  // Returns the number of points per set that the current count selects.
  function automatic int active_points();
    if (count_reg == 0) return 1;
    if (count_reg > NMAX) return NMAX;
    return count_reg;
  endfunction

  task automatic predict_request(bit point_set, shortint x, shortint y, output bit solved);
    int n;
    n = active_points();
    solved = 1'b0;
    if (points_loaded < n) begin
      if (point_set != 1'b0) return;
      first_x[points_loaded] = x;
      first_y[points_loaded] = y;
      points_loaded++;
      return;
    end
    if (point_set != 1'b1) return;
    second_x[points_loaded - n] = x;
    second_y[points_loaded - n] = y;
    points_loaded++;
    if (points_loaded < 2 * n) return;
    points_loaded = 0;
    solved = 1'b1;
    solve_assignment(n);
  endtask

  // Drives one request after a random gap and waits for its handshake.
  // The valid is only lowered when a gap follows, so back-to-back requests
  // never see two assignments to tvalid in one step.
  task automatic send_point(bit point_set, shortint x, shortint y, output bit solved);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= point_set;
    s_axis_tdata  <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    predict_request(point_set, x, y, solved);
  endtask

  // Configuration is written only with no result outstanding, plus a
  // short settle time for any load step still in flight.
  task automatic write_point_count(int value);
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = value & 6'h3f;
    points_loaded = 0;
  endtask

  function automatic shortint random_coord(bit wide);
    if (wide) return shortint'($urandom_range(0, 65535));
    return shortint'($urandom_range(0, 8)) - 16'sd4;
  endfunction

  // One full problem of n points per set, with occasional wrong-set noise.
  task automatic run_problem(int n, ref int good_items);
    bit wide, solved;
    wide = $urandom_range(0, 1);
    for (int k = 0; k < 2 * n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_point(k < n, random_coord(1), random_coord(1), solved);
      send_point(k >= n, random_coord(wide), random_coord(wide), solved);
      good_items++;
    end
  endtask

  // Output side: a random stall after every accepted result, with quiet
  // stretches in which the sink is always ready.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_stall = quiet ? 0 : $urandom_range(0, 17);
      if (out_stall > 0) begin
        m_axis_tready <= 1'b0;
        out_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    pair_result_t want;
    mcpa_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_BITS-1:0];
      results_seen++;
      if (expected_pairs.size() == 0) begin
        $error("result with no expectation pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.second_index !== want.fields.second_index) begin
          $error("second_index expected %0d actual %0d",
                 want.fields.second_index, got.second_index);
          fail_count++;
        end
        if (got.matched_first_index !== want.fields.matched_first_index) begin
          $error("matched_first_index expected %0d actual %0d",
                 want.fields.matched_first_index, got.matched_first_index);
          fail_count++;
        end
        if (got.pair_distance !== want.fields.pair_distance) begin
          $error("pair_distance expected %0d actual %0d",
                 want.fields.pair_distance, got.pair_distance);
          fail_count++;
        end
        if (got.total_cost !== want.fields.total_cost) begin
          $error("total_cost expected %0d actual %0d",
                 want.fields.total_cost, got.total_cost);
          fail_count++;
        end
        if (m_axis_tlast !== want.last_pair) begin
          $error("last_pair expected %0d actual %0d", want.last_pair, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    plan_row_t plan [12];
    int cfg_plan [8];
    int n, good_items, partial;
    bit solved;
    pair_result_t typed;

    // Directed rows at the reset count of one point per set.
    plan = '{
      '{1'b1, 16'sd5, 16'sd5, 1'b0, 0},            // wrong set, ignored
      '{1'b0, 16'sd0, 16'sd0, 1'b0, 0},
      '{1'b1, 16'sd3, 16'sd4, 1'b1, 5 * 1024},
      '{1'b0, -16'sd32768, -16'sd32768, 1'b0, 0},
      '{1'b1, 16'sd32767, 16'sd32767, 1'b0, 0},     // longest distance
      '{1'b0, 16'sd32767, -16'sd32768, 1'b0, 0},
      '{1'b1, 16'sd32767, -16'sd32768, 1'b1, 0},    // coincident points
      '{1'b0, 16'sd0, 16'sd0, 1'b0, 0},
      '{1'b1, 16'sd0, -16'sd1, 1'b1, 1024},
      '{1'b0, -16'sd7, 16'sd2, 1'b0, 0},
      '{1'b0, 16'sd100, 16'sd100, 1'b0, 0},         // second-set slot, ignored
      '{1'b1, -16'sd7, 16'sd2, 1'b1, 0}
    };
    cfg_plan = '{2, 3, 0, 5, 4, 63, 7, 1};

    count_reg = 1;
    points_loaded = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    quiet = 1'b1;
    foreach (plan[r]) begin
      send_point(plan[r].point_set, plan[r].x, plan[r].y, solved);
      // A typed row replaces the prediction it was derived from.
      if (plan[r].has_exp && solved) begin
        void'(expected_pairs.pop_back());
        typed.fields.second_index = '0;
        typed.fields.matched_first_index = '0;
        typed.fields.pair_distance = DIST_OUT_W'(plan[r].exp_dist);
        typed.fields.total_cost = TOTAL_W'(plan[r].exp_dist);
        typed.last_pair = 1'b1;
        expected_pairs.push_back(typed);
      end
      if (r == 5) quiet = 1'b0;
    end

    // Random phases over several point counts, the extremes among them.
    foreach (cfg_plan[p]) begin
      write_point_count(cfg_plan[p]);
      n = active_points();
      good_items = 0;
      while (good_items < 4) begin
        quiet = ($urandom_range(0, 3) == 0);
        run_problem(n, good_items);
      end
      // Leave a partial load behind for the next count write to discard.
      partial = $urandom_range(0, n - 1);
      for (int k = 0; k < partial; k++)
        send_point(1'b0, random_coord(1), random_coord(1), solved);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d point requests, solved %0d assignment problems, checked %0d results.",
             requests_sent, problems_solved, results_seen);
    $display("Point counts covered 1 to %0d, with wrong-set noise and discarded partial loads.",
             NMAX);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: min_cost_point_assignment_top.f
src/mcpa_pkg.sv
src/mcpa_dist.sv
src/mcpa_solver.sv
src/min_cost_point_assignment_top.sv
test/min_cost_point_assignment_top_tb.sv
